### src/switch_scan_debounce_edge_latch_macros.svh
// ----------------------------------------------------------------------------
// Switch scan debouncer assertion macros
// Shared property wrappers for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef SWITCH_SCAN_DEBOUNCE_EDGE_LATCH_MACROS_SVH
`define SWITCH_SCAN_DEBOUNCE_EDGE_LATCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSDEL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSDEL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ssdel_pkg.sv
// ----------------------------------------------------------------------------
// ssdel_pkg
// Types, codes and constants shared by the switch scan debouncer.
// ----------------------------------------------------------------------------
package ssdel_pkg;

    // Fixed field widths of the channels.
    localparam int SW_WIDTH     = 32;
    localparam int MODES_WIDTH  = 64;
    localparam int DEB_WIDTH    = 16;
    localparam int IDX_OUT_W    = 5;
    localparam int CMD_WIDTH    = 2;
    localparam int CFG_IDX_W    = 2;

    // Default configuration.
    localparam int                   NUM_INPUTS_DEF  = 32;
    localparam logic [DEB_WIDTH-1:0] DEFAULT_DEBOUNCE = 16'd50;

    // Commands carried by an input beat; code three is a no-op.
    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_SCAN = 2'd0,
        CMD_INIT = 2'd1,
        CMD_ACK  = 2'd2
    } cmd_t;

    // Per-input mode field.
    typedef enum logic [1:0] {
        MODE_STATE  = 2'd0,
        MODE_RISE   = 2'd1,
        MODE_FALL   = 2'd2,
        MODE_IGNORE = 2'd3
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODES    = 2'd0,
        CFG_ENABLE   = 2'd1,
        CFG_DEBOUNCE = 2'd2
    } cfg_idx_t;

    // Per-input debounce phase, one-hot.
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_LOW   = 5'b00010,
        PH_VHIGH = 5'b00100,
        PH_HIGH  = 5'b01000,
        PH_VLOW  = 5'b10000
    } phase_t;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [MODES_WIDTH-1:0] input_modes;
        logic [SW_WIDTH-1:0]    enable_mask;
        logic [DEB_WIDTH-1:0]   debounce_us;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic [CMD_WIDTH-1:0] command;
        logic [SW_WIDTH-1:0]  pins;
        logic [SW_WIDTH-1:0]  now_us;
        logic [SW_WIDTH-1:0]  clear_mask;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [SW_WIDTH-1:0]  valid_switch;
        logic [IDX_OUT_W-1:0] scanned_index;
        logic                 edge_latched;
    } res_t;

    // Mode field of input i.
    function automatic mode_t mode_of(logic [MODES_WIDTH-1:0] modes,
                                      logic [IDX_OUT_W-1:0] i);
        return mode_t'(modes[{i, 1'b0} +: 2]);
    endfunction

endpackage

### src/ssdel_if.sv
// ----------------------------------------------------------------------------
// ssdel_if
// Valid/ready channel interfaces of the switch scan debouncer.
// ----------------------------------------------------------------------------

// Scan item channel.
interface ssdel_in_if;
    logic                               valid;
    logic                               ready;
    logic [ssdel_pkg::CMD_WIDTH-1:0]    command;
    logic [ssdel_pkg::SW_WIDTH-1:0]     pins;
    logic [ssdel_pkg::SW_WIDTH-1:0]     now_us;
    logic [ssdel_pkg::SW_WIDTH-1:0]     clear_mask;

    modport source (output valid, command, pins, now_us, clear_mask, input ready);
    modport sink   (input valid, command, pins, now_us, clear_mask, output ready);
endinterface

// Result channel.
interface ssdel_out_if;
    logic                               valid;
    logic                               ready;
    logic [ssdel_pkg::SW_WIDTH-1:0]     valid_switch;
    logic [ssdel_pkg::IDX_OUT_W-1:0]    scanned_index;
    logic                               edge_latched;

    modport source (output valid, valid_switch, scanned_index, edge_latched, input ready);
    modport sink   (input valid, valid_switch, scanned_index, edge_latched, output ready);
endinterface

// Configuration write channel.
interface ssdel_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ssdel_pkg::CFG_IDX_W-1:0]    index;
    logic [ssdel_pkg::MODES_WIDTH-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/ssdel_cfg.sv
// ----------------------------------------------------------------------------
// ssdel_cfg
// Configuration register file: input modes, enable mask, debounce time.
// ----------------------------------------------------------------------------
module ssdel_cfg (
    input  logic                clk,
    input  logic                rst_n,
    ssdel_cfg_if.sink           cfg,
    output ssdel_pkg::cfg_t     cfg_regs
);

    ssdel_pkg::cfg_t cfg_reg;

    // Writes are always taken; ready is tied high.
    assign cfg.ready = 1'b1;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_modes <= '0;
            cfg_reg.enable_mask <= '0;
            cfg_reg.debounce_us <= ssdel_pkg::DEFAULT_DEBOUNCE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ssdel_pkg::CFG_MODES:
                    cfg_reg.input_modes <= cfg.data;
                ssdel_pkg::CFG_ENABLE:
                    cfg_reg.enable_mask <= cfg.data[ssdel_pkg::SW_WIDTH-1:0];
                ssdel_pkg::CFG_DEBOUNCE:
                    cfg_reg.debounce_us <= cfg.data[ssdel_pkg::DEB_WIDTH-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg_regs = cfg_reg;

endmodule

### src/ssdel_ptr_sel.sv
// ----------------------------------------------------------------------------
// ssdel_ptr_sel
// Round-robin pick of the next enabled input after the current one.
// ----------------------------------------------------------------------------
module ssdel_ptr_sel #(
    parameter  int NUM_INPUTS = ssdel_pkg::NUM_INPUTS_DEF,
    localparam int IDX_W      = $clog2(NUM_INPUTS)
) (
    input  logic [NUM_INPUTS-1:0] en,
    input  logic [IDX_W-1:0]      cur,
    output logic [IDX_W-1:0]      nxt
);

    logic [NUM_INPUTS-1:0] upper;
    logic [IDX_W-1:0]      first_up;
    logic [IDX_W-1:0]      first_any;

    // Lowest enabled input above the current one, else the lowest overall.
    always_comb
    begin
        first_up  = '0;
        first_any = '0;
        for (int i = 0; i < NUM_INPUTS; i++)
        begin
            upper[i] = en[i] && (IDX_W'(i) > cur);
        end
        for (int i = NUM_INPUTS - 1; i >= 0; i--)
        begin
            if (upper[i])
            begin
                first_up = IDX_W'(i);
            end
            if (en[i])
            begin
                first_any = IDX_W'(i);
            end
        end
        nxt = (upper != '0) ? first_up : first_any;
    end

endmodule

### src/ssdel_engine.sv
// ----------------------------------------------------------------------------
// ssdel_engine
// Debounce state, scan pointer and latched word; computes one result per item.
// ----------------------------------------------------------------------------
module ssdel_engine #(
    parameter int NUM_INPUTS = ssdel_pkg::NUM_INPUTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ssdel_pkg::cfg_t     cfg_regs,
    input  ssdel_pkg::item_t    item,
    input  logic                fire,
    output ssdel_pkg::res_t     res
);

    localparam int IDX_W = $clog2(NUM_INPUTS);
    localparam int W     = ssdel_pkg::SW_WIDTH;

    ssdel_pkg::phase_t     phase_reg  [NUM_INPUTS];
    ssdel_pkg::phase_t     phase_next [NUM_INPUTS];
    logic [W-1:0]          start_reg  [NUM_INPUTS];
    logic [IDX_W-1:0]      ptr_reg;
    logic [IDX_W-1:0]      ptr_next;
    logic [W-1:0]          latched_reg;
    logic [W-1:0]          latched_next;

    logic [W-1:0]                       present;
    logic [W-1:0]                       en;
    logic [W-1:0]                       pins_en;
    logic [W-1:0]                       state_m;
    logic [W-1:0]                       init_latch;
    ssdel_pkg::phase_t                  init_phase [NUM_INPUTS];
    logic [ssdel_pkg::IDX_OUT_W-1:0]    cur5;
    ssdel_pkg::mode_t                   cur_mode;
    logic                               cur_high;
    logic                               step_ok;
    logic                               held;
    logic                               scan_live;
    ssdel_pkg::phase_t                  ph_new;
    logic                               st_set;
    logic                               edge_hit;
    logic [W-1:0]                       stepped;

    // Present inputs, enabled inputs and state-mode inputs.
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            present[i] = (i < NUM_INPUTS);
            state_m[i] = present[i] && (ssdel_pkg::mode_of(cfg_regs.input_modes,
                         ssdel_pkg::IDX_OUT_W'(i)) == ssdel_pkg::MODE_STATE);
        end
        en      = cfg_regs.enable_mask & present;
        pins_en = item.pins & en;
    end

    // The input under the scan pointer.
    assign cur5      = ssdel_pkg::IDX_OUT_W'(ptr_reg);
    assign cur_mode  = ssdel_pkg::mode_of(cfg_regs.input_modes, cur5);
    assign cur_high  = pins_en[cur5];
    assign step_ok   = en[cur5] && (cur_mode == ssdel_pkg::MODE_RISE ||
                                    cur_mode == ssdel_pkg::MODE_FALL);
    assign held      = (item.now_us - start_reg[ptr_reg]) >= W'(cfg_regs.debounce_us);
    assign scan_live = (item.command == ssdel_pkg::CMD_SCAN) && (en != '0);

    // One step of the four-phase debounce machine for the scanned input.
    always_comb
    begin
        ph_new   = phase_reg[ptr_reg];
        st_set   = 1'b0;
        edge_hit = 1'b0;
        case (phase_reg[ptr_reg])
            ssdel_pkg::PH_LOW:
            begin
                if (cur_high)
                begin
                    ph_new = ssdel_pkg::PH_VHIGH;
                    st_set = 1'b1;
                end
            end
            ssdel_pkg::PH_VHIGH:
            begin
                if (!cur_high)
                begin
                    ph_new = ssdel_pkg::PH_LOW;
                end
                else if (held)
                begin
                    ph_new   = ssdel_pkg::PH_HIGH;
                    edge_hit = (cur_mode == ssdel_pkg::MODE_RISE);
                end
            end
            ssdel_pkg::PH_HIGH:
            begin
                if (!cur_high)
                begin
                    ph_new = ssdel_pkg::PH_VLOW;
                    st_set = 1'b1;
                end
            end
            ssdel_pkg::PH_VLOW:
            begin
                if (cur_high)
                begin
                    ph_new = ssdel_pkg::PH_HIGH;
                end
                else if (held)
                begin
                    ph_new   = ssdel_pkg::PH_LOW;
                    edge_hit = (cur_mode == ssdel_pkg::MODE_FALL);
                end
            end
            default:
                ;
        endcase
    end

    // Phases and latches that an init command derives from the pins.
    always_comb
    begin
        init_latch = '0;
        for (int i = 0; i < NUM_INPUTS; i++)
        begin
            init_phase[i] = phase_reg[i];
            case (ssdel_pkg::mode_of(cfg_regs.input_modes, ssdel_pkg::IDX_OUT_W'(i)))
                ssdel_pkg::MODE_STATE:
                    init_phase[i] = ssdel_pkg::PH_IDLE;
                ssdel_pkg::MODE_RISE:
                begin
                    init_phase[i] = pins_en[i] ? ssdel_pkg::PH_HIGH : ssdel_pkg::PH_LOW;
                    init_latch[i] = pins_en[i];
                end
                ssdel_pkg::MODE_FALL:
                begin
                    init_phase[i] = pins_en[i] ? ssdel_pkg::PH_HIGH : ssdel_pkg::PH_LOW;
                    init_latch[i] = !pins_en[i];
                end
                default:
                    ;
            endcase
        end
    end

    // Next scan pointer.
    ssdel_ptr_sel #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_ptr_sel (
        .en  (en[NUM_INPUTS-1:0]),
        .cur (ptr_reg),
        .nxt (ptr_next)
    );

    // Next phases and latched word for the command at hand.
    always_comb
    begin
        stepped      = latched_reg;
        stepped[cur5] = latched_reg[cur5] | (step_ok && edge_hit);
        latched_next = latched_reg;
        for (int i = 0; i < NUM_INPUTS; i++)
        begin
            phase_next[i] = phase_reg[i];
        end
        case (item.command)
            ssdel_pkg::CMD_SCAN:
            begin
                if (scan_live)
                begin
                    if (step_ok)
                    begin
                        phase_next[ptr_reg] = ph_new;
                    end
                    latched_next = (stepped & ~state_m) | (pins_en & state_m);
                end
            end
            ssdel_pkg::CMD_INIT:
            begin
                for (int i = 0; i < NUM_INPUTS; i++)
                begin
                    phase_next[i] = init_phase[i];
                end
                latched_next = init_latch | (pins_en & state_m);
            end
            ssdel_pkg::CMD_ACK:
                latched_next = latched_reg & ~item.clear_mask;
            default:
                ;
        endcase
    end

    // State update when the item moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                phase_reg[i] <= ssdel_pkg::PH_IDLE;
                start_reg[i] <= '0;
            end
            ptr_reg     <= '0;
            latched_reg <= '0;
        end
        else if (fire)
        begin
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                phase_reg[i] <= phase_next[i];
            end
            latched_reg <= latched_next;
            if (scan_live)
            begin
                ptr_reg <= ptr_next;
            end
            if (scan_live && step_ok && st_set)
            begin
                start_reg[ptr_reg] <= item.now_us;
            end
        end
    end

    // Result fields.
    assign res.valid_switch  = latched_next;
    assign res.scanned_index = scan_live ? cur5 : '0;
    assign res.edge_latched  = scan_live && step_ok && edge_hit;

endmodule

### src/switch_scan_debounce_edge_latch.sv
// ----------------------------------------------------------------------------
// switch_scan_debounce_edge_latch
// Round-robin switch debouncer with rise/fall edge latching.
// ----------------------------------------------------------------------------
//   Port    Direction  Beat carries
//   scan    sink       command, pins, now_us, clear_mask
//   result  source     valid_switch, scanned_index, edge_latched
//   cfg     sink       index, data (register write)
//
// A beat enters the input register and moves through the debounce step into the
// result register once that register is free; its result leaves from there.
// A new beat is accepted every cycle while the result side does not stall; the
// phase store, scan pointer and latched word are updated as each beat moves on.
// Reset clears all phases to idle, the pointer and the latched word.
// A stalled result holds the item in the input register; scan.ready drops
// only when both registers are full and result.ready is low.
// ----------------------------------------------------------------------------
module switch_scan_debounce_edge_latch #(
    parameter int NUM_INPUTS = ssdel_pkg::NUM_INPUTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ssdel_in_if.sink    scan,
    ssdel_out_if.source result,
    ssdel_cfg_if.sink   cfg
);

    ssdel_pkg::cfg_t  cfg_regs;
    ssdel_pkg::item_t item_reg;
    ssdel_pkg::res_t  res_comb;
    ssdel_pkg::res_t  res_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             fire;
    logic             take;

    // Configuration registers.
    ssdel_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    // Handshake: move the held item on whenever the result slot frees.
    assign fire       = in_valid_reg && (!out_valid_reg || result.ready);
    assign scan.ready = !in_valid_reg || fire;
    assign take       = scan.valid && scan.ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take || fire)
        begin
            in_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.command    <= scan.command;
            item_reg.pins       <= scan.pins;
            item_reg.now_us     <= scan.now_us;
            item_reg.clear_mask <= scan.clear_mask;
        end
    end

    // Debounce step and state.
    ssdel_engine #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs),
        .item     (item_reg),
        .fire     (fire),
        .res      (res_comb)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_comb;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.valid_switch  = res_reg.valid_switch;
    assign result.scanned_index = res_reg.scanned_index;
    assign result.edge_latched  = res_reg.edge_latched;

endmodule

### src/ssdel_checker.sv
// ----------------------------------------------------------------------------
// ssdel_checker
// Port-level checks on the result channel of the switch scan debouncer.
// ----------------------------------------------------------------------------
`include "switch_scan_debounce_edge_latch_macros.svh"

module ssdel_checker #(
    parameter int NUM_INPUTS = ssdel_pkg::NUM_INPUTS_DEF
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 res_valid,
    input logic                                 res_ready,
    input logic [ssdel_pkg::SW_WIDTH-1:0]       valid_switch,
    input logic [ssdel_pkg::IDX_OUT_W-1:0]      scanned_index,
    input logic                                 edge_latched
);

    // A confirmed edge must show its bit set in the same result.
    `SSDEL_ASSERT_SAME(a_edge_bit_set, clk, rst_n, res_valid && edge_latched, valid_switch[scanned_index], "edge reported without its latched bit")

    // The scanned input is always one that exists.
    `SSDEL_ASSERT_SAME(a_index_range, clk, rst_n, res_valid, int'(scanned_index) < NUM_INPUTS, "scanned index beyond the input count")

    // A stalled result stays valid and unchanged.
    `SSDEL_ASSERT_NEXT(a_result_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(valid_switch) && $stable(scanned_index) && $stable(edge_latched), "stalled result changed")

endmodule

bind switch_scan_debounce_edge_latch ssdel_checker #(
    .NUM_INPUTS (NUM_INPUTS)
) u_ssdel_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .valid_switch  (result.valid_switch),
    .scanned_index (result.scanned_index),
    .edge_latched  (result.edge_latched)
);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the round-robin switch debouncer. A short scripted
// sequence covers reset values, field extremes, every command and the corner
// cases of the debounce machine. Randomized phases then run with different
// register settings. A local model of the phase store, scan pointer and
// latched word predicts every result beat, and each beat is compared field by
// field in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ssdel_pkg::*;

    // Command code three is reserved and must act as a no-op.
    localparam logic [CMD_WIDTH-1:0] CMD_RESERVED = 2'd3;
    localparam int NUM_SW = 32;
    localparam int MAX_REPORTS = 10;

    // One row of the scripted sequence: a register write or a scan beat.
    typedef struct {
        bit                     is_reg;
        cfg_idx_t               reg_idx;
        logic [MODES_WIDTH-1:0] reg_value;
        item_t                  beat;
        bit                     pinned;
        res_t                   value;
    } script_row_t;

    // Expected value fixed by the script, or left to the model.
    typedef struct {
        bit   pinned;
        res_t value;
    } typed_result_t;

    logic clk;
    logic rst_n;

    ssdel_in_if  scan ();
    ssdel_out_if result ();
    ssdel_cfg_if cfg ();

    switch_scan_debounce_edge_latch dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan),
        .result (result),
        .cfg    (cfg)
    );

    // Local copy of the registers and the debounce state.
    logic [MODES_WIDTH-1:0] m_modes;
    logic [SW_WIDTH-1:0]    m_enable;
    logic [DEB_WIDTH-1:0]   m_debounce;
    phase_t                 sw_phase [NUM_SW];
    logic [SW_WIDTH-1:0]    sw_start [NUM_SW];
    logic [IDX_OUT_W-1:0]   scan_ptr;
    logic [SW_WIDTH-1:0]    latched_word;

    res_t          pending_results [$];
    typed_result_t typed_results [$];
    script_row_t   script [$];

    int unsigned n_sent;
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_reg_writes;
    int unsigned n_edges;
    bit          no_idle;
    int unsigned rx_hold_len;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mode field of one input in the local register copy.
    function automatic mode_t input_mode(int unsigned i);
        return mode_t'(m_modes[2*i +: 2]);
    endfunction

    // Inputs configured as live level copies.
    function automatic logic [SW_WIDTH-1:0] state_mode_inputs();
        logic [SW_WIDTH-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_SW; i++)
        begin
            if (input_mode(i) == MODE_STATE)
                m[i] = 1'b1;
        end
        return m;
    endfunction

    // Applies one accepted beat to the local state and returns its result.
    function automatic res_t debounce_step(item_t beat);
        res_t                r;
        logic [SW_WIDTH-1:0] en;
        logic [SW_WIDTH-1:0] pins;
        logic [SW_WIDTH-1:0] sm;
        logic [SW_WIDTH-1:0] elapsed;
        int unsigned         i;
        int unsigned         j;
        mode_t               md;
        logic                high;
        logic                held;
        logic                found;
        r = '0;
        en = m_enable;
        pins = beat.pins & en;
        case (beat.command)
            CMD_SCAN:
            begin
                if (en != '0)
                begin
                    i = scan_ptr;
                    md = input_mode(i);
                    high = pins[i];
                    r.scanned_index = scan_ptr;
                    if (en[i] && (md == MODE_RISE || md == MODE_FALL))
                    begin
                        elapsed = beat.now_us - sw_start[i];
                        held = (elapsed >= {16'd0, m_debounce});
                        case (sw_phase[i])
                            PH_LOW:
                            begin
                                if (high)
                                begin
                                    sw_phase[i] = PH_VHIGH;
                                    sw_start[i] = beat.now_us;
                                end
                            end
                            PH_VHIGH:
                            begin
                                if (!high)
                                    sw_phase[i] = PH_LOW;
                                else if (held)
                                begin
                                    sw_phase[i] = PH_HIGH;
                                    if (md == MODE_RISE)
                                    begin
                                        latched_word[i] = 1'b1;
                                        r.edge_latched = 1'b1;
                                    end
                                end
                            end
                            PH_HIGH:
                            begin
                                if (!high)
                                begin
                                    sw_phase[i] = PH_VLOW;
                                    sw_start[i] = beat.now_us;
                                end
                            end
                            PH_VLOW:
                            begin
                                if (high)
                                    sw_phase[i] = PH_HIGH;
                                else if (held)
                                begin
                                    sw_phase[i] = PH_LOW;
                                    if (md == MODE_FALL)
                                    begin
                                        latched_word[i] = 1'b1;
                                        r.edge_latched = 1'b1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    // The pointer moves to the next enabled input, wrapping.
                    j = i;
                    found = 1'b0;
                    for (int k = 0; k < NUM_SW; k++)
                    begin
                        if (!found)
                        begin
                            j = (j + 1) % NUM_SW;
                            found = en[j];
                        end
                    end
                    scan_ptr = j[IDX_OUT_W-1:0];
                    sm = state_mode_inputs();
                    latched_word = (latched_word & ~sm) | (pins & sm);
                end
            end
            CMD_INIT:
            begin
                sm = state_mode_inputs();
                latched_word = '0;
                for (int n = 0; n < NUM_SW; n++)
                begin
                    case (input_mode(n))
                        MODE_STATE: sw_phase[n] = PH_IDLE;
                        MODE_RISE:
                        begin
                            if (pins[n])
                            begin
                                latched_word[n] = 1'b1;
                                sw_phase[n] = PH_HIGH;
                            end
                            else
                                sw_phase[n] = PH_LOW;
                        end
                        MODE_FALL:
                        begin
                            if (!pins[n])
                            begin
                                latched_word[n] = 1'b1;
                                sw_phase[n] = PH_LOW;
                            end
                            else
                                sw_phase[n] = PH_HIGH;
                        end
                        default: ;
                    endcase
                end
                latched_word = latched_word | (pins & sm);
            end
            CMD_ACK: latched_word = latched_word & ~beat.clear_mask;
            default: ;
        endcase
        r.valid_switch = latched_word;
        return r;
    endfunction

    // Tracks register writes and input beats, and checks result beats.
    always @(posedge clk)
    begin : track_beats
        item_t         beat;
        res_t          got;
        res_t          want;
        res_t          predicted;
        typed_result_t typed;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                got = {result.valid_switch, result.scanned_index, result.edge_latched};
                if (got.edge_latched === 1'b1)
                    n_edges++;
                if (pending_results.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("[%0t] result beat with nothing expected: %h %0d %b",
                                 $realtime, got.valid_switch, got.scanned_index,
                                 got.edge_latched);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.valid_switch !== want.valid_switch ||
                        got.scanned_index !== want.scanned_index ||
                        got.edge_latched !== want.edge_latched)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("[%0t] result %0d mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                     $realtime, n_checked, want.valid_switch,
                                     want.scanned_index, want.edge_latched,
                                     got.valid_switch, got.scanned_index,
                                     got.edge_latched);
                    end
                end
                n_checked++;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_idx_t'(cfg.index))
                    CFG_MODES:    m_modes = cfg.data;
                    CFG_ENABLE:   m_enable = cfg.data[SW_WIDTH-1:0];
                    CFG_DEBOUNCE: m_debounce = cfg.data[DEB_WIDTH-1:0];
                    default: ;
                endcase
                n_reg_writes++;
            end
            if (scan.valid && scan.ready)
            begin
                beat = {scan.command, scan.pins, scan.now_us, scan.clear_mask};
                predicted = debounce_step(beat);
                typed = typed_results.pop_front();
                pending_results.push_back(typed.pinned ? typed.value : predicted);
            end
        end
    end

    // Result side: random stalls per beat, with one long hold on request.
    initial
    begin : result_sink
        int unsigned stall;
        result.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold_len != 0)
            begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end
            else if (no_idle)
                stall = 0;
            else
                stall = $urandom_range(0, 5);
            if (stall != 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result.valid);
        end
    end

    // Appends a scan beat to the script.
    task automatic script_beat(logic [CMD_WIDTH-1:0] cmd, logic [SW_WIDTH-1:0] pins,
                               logic [SW_WIDTH-1:0] now, logic [SW_WIDTH-1:0] clr,
                               bit pinned, res_t value);
        script_row_t row;
        row.is_reg = 1'b0;
        row.reg_idx = CFG_MODES;
        row.reg_value = '0;
        row.beat = {cmd, pins, now, clr};
        row.pinned = pinned;
        row.value = value;
        script.push_back(row);
    endtask

    // Appends a register write to the script.
    task automatic script_reg(cfg_idx_t idx, logic [MODES_WIDTH-1:0] value);
        script_row_t row;
        row.is_reg = 1'b1;
        row.reg_idx = idx;
        row.reg_value = value;
        row.beat = '0;
        row.pinned = 1'b0;
        row.value = '0;
        script.push_back(row);
    endtask

    // Offers one scan beat after a random gap and waits until it is taken.
    task automatic send_beat(item_t beat, bit pinned, res_t value);
        int unsigned   gap;
        typed_result_t typed;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        typed.pinned = pinned;
        typed.value = value;
        typed_results.push_back(typed);
        if (gap != 0)
        begin
            scan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan.valid      <= 1'b1;
        scan.command    <= beat.command;
        scan.pins       <= beat.pins;
        scan.now_us     <= beat.now_us;
        scan.clear_mask <= beat.clear_mask;
        do
            @(posedge clk);
        while (!scan.ready);
        n_sent++;
    endtask

    // Writes one register; the valid is dropped only after the last of a group.
    task automatic write_reg(cfg_idx_t idx, logic [MODES_WIDTH-1:0] value, bit last);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (last)
            cfg.valid <= 1'b0;
    endtask

    // Stops offering beats and waits until every result has come back.
    task automatic wait_drained();
        scan.valid <= 1'b0;
        while (n_checked != n_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Stimulus: reset, scripted sequence, then randomized phases.
    initial
    begin : stimulus
        script_row_t            row;
        item_t                  beat;
        logic [MODES_WIDTH-1:0] modes;
        logic [SW_WIDTH-1:0]    enable;
        logic [SW_WIDTH-1:0]    levels;
        logic [SW_WIDTH-1:0]    clock_us;
        logic [DEB_WIDTH-1:0]   deb;
        logic [CMD_WIDTH-1:0]   cmd;
        int unsigned            step_max;
        int unsigned            roll;
        m_modes = '0;
        m_enable = '0;
        m_debounce = DEFAULT_DEBOUNCE;
        for (int i = 0; i < NUM_SW; i++)
        begin
            sw_phase[i] = PH_IDLE;
            sw_start[i] = '0;
        end
        scan_ptr = '0;
        latched_word = '0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        n_reg_writes = 0;
        n_edges = 0;
        no_idle = 1'b0;
        rx_hold_len = 0;
        rst_n = 1'b0;
        scan.valid      <= 1'b0;
        scan.command    <= CMD_SCAN;
        scan.pins       <= '0;
        scan.now_us     <= '0;
        scan.clear_mask <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= CFG_MODES;
        cfg.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing enabled after reset: every command returns zeros.
        script_beat(CMD_SCAN, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, '0);
        script_beat(CMD_INIT, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, '0);
        script_beat(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0);
        script_beat(CMD_ACK, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, '0);
        // All inputs in state mode copy the pins straight through.
        script_reg(CFG_ENABLE, 64'hFFFF_FFFF);
        script_beat(CMD_SCAN, 32'hA5A5_A5A5, 32'h0, 32'h0, 1'b1,
                    {32'hA5A5_A5A5, 5'd0, 1'b0});
        script_beat(CMD_SCAN, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1,
                    {32'hFFFF_FFFF, 5'd1, 1'b0});
        script_beat(CMD_ACK, 32'h0, 32'h0, 32'h0000_FFFF, 1'b1,
                    {32'hFFFF_0000, 5'd0, 1'b0});
        script_beat(CMD_SCAN, 32'h0, 32'h0, 32'h0, 1'b1, {32'h0, 5'd2, 1'b0});
        // Mixed modes and zero threshold; edge inputs are still idle here.
        script_reg(CFG_MODES, 64'hE4E4_E4E4_E4E4_E4E4);
        script_reg(CFG_DEBOUNCE, 64'h0);
        script_beat(CMD_SCAN, 32'hFFFF_FFFF, 32'h10, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'hFFFF_FFFF, 32'h10, 32'h0, 1'b0, '0);
        // Only one rising and one falling input enabled; pointer sits on a
        // disabled input first.
        script_reg(CFG_ENABLE, 64'h0000_0006);
        script_beat(CMD_SCAN, 32'h0, 32'h20, 32'h0, 1'b0, '0);
        script_beat(CMD_INIT, 32'h0000_0004, 32'h20, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0002, 32'd100, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0000, 32'd100, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0002, 32'd100, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0000, 32'd100, 32'h0, 1'b0, '0);
        script_beat(CMD_ACK, 32'h0, 32'd100, 32'h0000_0006, 1'b0, '0);
        // Largest threshold with bounces and a time wrap.
        script_reg(CFG_DEBOUNCE, 64'hFFFF);
        script_beat(CMD_SCAN, 32'h0000_0000, 32'hFFFF_FFF0, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0004, 32'hFFFF_FFF0, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0002, 32'hFFFF_FFF8, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0000, 32'hFFFF_FFF8, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0000, 32'hFFFF_FFF0, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0004, 32'hFFFF_FFF0, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0000, 32'h0000_FFEE, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0004, 32'h0000_FFEF, 32'h0, 1'b0, '0);
        script_beat(CMD_SCAN, 32'h0000_0000, 32'h0000_FFEF, 32'h0, 1'b0, '0);

        for (int r = 0; r < script.size(); r++)
        begin
            row = script[r];
            if (row.is_reg)
            begin
                if (r == 0 || !script[r-1].is_reg)
                    wait_drained();
                write_reg(row.reg_idx, row.reg_value,
                          (r + 1 >= script.size()) || !script[r+1].is_reg);
            end
            else
                send_beat(row.beat, row.pinned, row.value);
        end

        // Randomized phases, each with its own register setting.
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0:  modes = {32{MODE_RISE}};
                1:  modes = {32{MODE_FALL}};
                4:  modes = {32{MODE_IGNORE}};
                5:  modes = {32{MODE_STATE}};
                default: modes = {$urandom, $urandom};
            endcase
            case (ph)
                2, 5:  enable = 32'hFFFF_FFFF;
                4:     enable = $urandom;
                6:     enable = '0;
                default: enable = ($urandom & $urandom & $urandom)
                                  | (32'd1 << $urandom_range(0, 31));
            endcase
            case (ph)
                1, 7:  deb = '0;
                3:     deb = 16'hFFFF;
                default: deb = $urandom_range(1, 40);
            endcase
            step_max = (deb >> 2) + 3;
            wait_drained();
            write_reg(CFG_MODES, modes, 1'b0);
            write_reg(CFG_ENABLE, {32'd0, enable}, 1'b0);
            write_reg(CFG_DEBOUNCE, {48'd0, deb}, 1'b1);
            no_idle = (ph % 4 == 3);
            levels = $urandom;
            clock_us = $urandom;
            beat = {CMD_INIT, levels, clock_us, $urandom};
            send_beat(beat, 1'b0, '0);
            for (int n = 0; n < 62; n++)
            begin
                // Hold the result side off while the sender keeps pushing.
                if (ph == 2 && n == 10)
                begin
                    no_idle = 1'b1;
                    rx_hold_len = 60;
                end
                if (ph == 2 && n == 40)
                    no_idle = 1'b0;
                if (ph == 5 && n == 30)
                    wait_drained();
                clock_us = clock_us + $urandom_range(0, step_max);
                if ($urandom_range(0, 15) == 0)
                    clock_us = $urandom;
                if ($urandom_range(0, 7) == 0)
                    levels = levels ^ (enable & $urandom);
                roll = $urandom_range(0, 99);
                beat.pins = levels;
                if (roll < 3)
                    beat.pins = $urandom;
                else if (roll < 10)
                    beat.pins = levels ^ (32'd1 << $urandom_range(0, 31));
                roll = $urandom_range(0, 99);
                if (roll < 86)
                    cmd = CMD_SCAN;
                else if (roll < 91)
                    cmd = CMD_ACK;
                else if (roll < 96)
                    cmd = CMD_INIT;
                else
                    cmd = CMD_RESERVED;
                beat.command = cmd;
                beat.now_us = clock_us;
                beat.clear_mask = $urandom;
                send_beat(beat, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        // Drain and let the pipeline settle before the verdict.
        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            n_errors += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("Run covered %0d scan beats, %0d result beats and %0d register writes,",
                 n_sent, n_checked, n_reg_writes);
        $display("with %0d confirmed edges across 12 random settings; %0d errors.",
                 n_edges, n_errors);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin : watchdog
        #4ms;
        $display("Timeout with %0d of %0d results checked", n_checked, n_sent);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
